[hdl/line_sensor_centroid_core_defines.svh]
// Assertion macros shared by the line sensor centroid RTL.
// Each check is sampled on the rising edge of clock and is ignored while reset is high.
`ifndef LINE_SENSOR_CENTROID_CORE_DEFINES_SVH
`define LINE_SENSOR_CENTROID_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LSC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed (same cycle)");
`define LSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed (next cycle)");
`else
`define LSC_ASSERT_IMP(lbl, ante, cons)
`define LSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/lsc_pkg.sv]
package lsc_pkg;

   localparam int SENSOR_NUM_DEF = 16;
   localparam int ADC_BITS_DEF   = 12;

   localparam int DIV_NUM_W = 28;
   localparam int DIV_DEN_W = 14;

   localparam logic [1:0] OP_SAMPLE   = 2'd0;
   localparam logic [1:0] OP_WHITE    = 2'd1;
   localparam logic [1:0] OP_BLACK    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] CSR_MIN_CAL_RANGE    = 2'd0;
   localparam logic [1:0] CSR_INVERT_POLARITY  = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_MIN_STRENGTH_SUM = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  sensor_index;
      logic [11:0] sample_value;
      logic        last_of_scan;
   } lsc_req_type;

   typedef struct packed {
      logic signed [13:0] line_position;
      logic [4:0]         active_count;
      logic [13:0]        total_strength;
      logic               line_found;
      logic               cal_locked;
   } lsc_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lsc_div_stat_type;

   // sensor weight: -7500 + 1000 * index
   function automatic logic signed [14:0] weight_of(input logic [3:0] idx);
      logic [14:0] w;
      w = 15'(idx) * 15'd1000 - 15'd7500;
      return signed'(w);
   endfunction

endpackage

[hdl/lsc_div.sv]
module lsc_div
   import lsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quot,
   output lsc_div_stat_type     stat
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         rem_in  = fits ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : DIV_DEN_W'(shifted);
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/line_sensor_centroid_core.sv]
// Loads are applied straight from idle. A sample runs a bit-serial normalization divide,
// then hand-off, multiply and accumulate; a sensor with no usable span, or a sample below
// its black level, skips the divide. A last sample adds a second divide for the centroid;
// with too little strength it skips that divide, and an unlocked one goes straight to finish.
// One request at a time; a finished response waits in its own register and holds the next.
// Synchronous active-high reset clears calibration, lock, accumulators, held position.
`include "line_sensor_centroid_core_defines.svh"

module line_sensor_centroid_core
   import lsc_pkg::*;
#(
   parameter int SENSOR_NUM = SENSOR_NUM_DEF,
   parameter int ADC_BITS   = ADC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lsc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lsc_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam int IDX_W = $clog2(SENSOR_NUM);
   localparam logic [11:0] VAL_MASK =
      (ADC_BITS >= 12) ? 12'hFFF : 12'((1 << ADC_BITS) - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV1 = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_POS  = 3'd4;
   localparam logic [2:0] S_DIV2 = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]  state_ff, state_in;

   // configuration registers
   logic [11:0] min_cal_range_ff, min_cal_range_in;
   logic        invert_ff, invert_in;
   logic [9:0]  active_thr_ff, active_thr_in;
   logic [13:0] min_sum_ff, min_sum_in;

   // calibration
   logic [11:0]           white_ff [SENSOR_NUM];
   logic [11:0]           white_in [SENSOR_NUM];
   logic [11:0]           black_ff [SENSOR_NUM];
   logic [11:0]           black_in [SENSOR_NUM];
   logic [SENSOR_NUM-1:0] valid_ff, valid_in;
   logic                  locked_ff, locked_in;

   // scan working state
   logic [3:0]         idx_ff, idx_in;
   logic               last_ff, last_in;
   logic [9:0]         s_ff, s_in;
   logic signed [25:0] prod_ff, prod_in;
   logic signed [27:0] weighted_ff, weighted_in;
   logic [13:0]        strength_ff, strength_in;
   logic [4:0]         active_ff, active_in;
   logic signed [13:0] held_ff, held_in;
   logic               neg_ff, neg_in;

   logic        rsp_valid_ff, rsp_valid_in;
   lsc_rsp_type rsp_data_ff, rsp_data_in;

   // divider hookup
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quot;
   lsc_div_stat_type     div_stat;

   // combinational helpers
   logic               accept;
   logic [11:0]        raw;
   logic               in_range;
   logic [IDX_W-1:0]   addr;
   logic [11:0]        cur_w, cur_b, new_w, new_b;
   logic [12:0]        cal_diff;
   logic               sensor_ok;
   logic [11:0]        diff;
   logic [21:0]        scaled;
   logic [9:0]         qc;
   logic [9:0]         sz;
   logic [14:0]        ssum;
   logic signed [28:0] wsum;
   logic [13:0]        pos_mag;

   lsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign raw       = req_data.sample_value & VAL_MASK;
   assign in_range  = (32'(req_data.sensor_index) < SENSOR_NUM);
   assign addr      = IDX_W'(req_data.sensor_index);
   assign cur_w     = white_ff[addr];
   assign cur_b     = black_ff[addr];
   assign diff      = raw - cur_b;
   // times 1000 as 1024 - 16 - 8
   assign scaled    = (22'(diff) << 10) - (22'(diff) << 4) - (22'(diff) << 3);

   always_comb begin
      state_in         = state_ff;
      min_cal_range_in = min_cal_range_ff;
      invert_in        = invert_ff;
      active_thr_in    = active_thr_ff;
      min_sum_in       = min_sum_ff;
      white_in         = white_ff;
      black_in         = black_ff;
      valid_in         = valid_ff;
      locked_in        = locked_ff;
      idx_in           = idx_ff;
      last_in          = last_ff;
      s_in             = s_ff;
      prod_in          = prod_ff;
      weighted_in      = weighted_ff;
      strength_in      = strength_ff;
      active_in        = active_ff;
      held_in          = held_ff;
      neg_in           = neg_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      div_start        = 1'b0;
      div_num          = DIV_NUM_W'(scaled);
      div_den          = DIV_DEN_W'(cur_w - cur_b);
      new_w            = (req_data.operation == OP_WHITE) ? raw : cur_w;
      new_b            = (req_data.operation == OP_BLACK) ? raw : cur_b;
      cal_diff         = {1'b0, new_w} - {1'b0, new_b};
      sensor_ok        = in_range && valid_ff[addr];
      qc               = (div_quot > DIV_NUM_W'(1000)) ? 10'd1000 : div_quot[9:0];
      sz               = (s_ff < 10'd80) ? 10'd0 : s_ff;
      ssum             = {1'b0, strength_ff} + {5'd0, sz};
      wsum             = 29'(weighted_ff) + 29'(prod_ff);
      pos_mag          = (div_quot > DIV_NUM_W'(7500)) ? 14'd7500 : div_quot[13:0];

      // configuration writes must arrive only while idle; the block itself leaves this unchecked
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_CAL_RANGE:    min_cal_range_in = csr_data[11:0];
            CSR_INVERT_POLARITY:  invert_in        = csr_data[0];
            CSR_ACTIVE_THRESHOLD: active_thr_in    = csr_data[9:0];
            CSR_MIN_STRENGTH_SUM: min_sum_in       = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req_data.operation == OP_WHITE || req_data.operation == OP_BLACK)
                   && !locked_ff) begin
                  // store the value, recheck this sensor's span, then the lock
                  if (in_range) begin
                     white_in[addr] = new_w;
                     black_in[addr] = new_b;
                     valid_in[addr] = !cal_diff[12] && (cal_diff[11:0] >= min_cal_range_ff);
                  end
                  if (req_data.last_of_scan && (&valid_in)) begin
                     locked_in = 1'b1;
                  end
               end else if (req_data.operation == OP_SAMPLE) begin
                  idx_in  = req_data.sensor_index;
                  last_in = req_data.last_of_scan;
                  if (locked_ff) begin
                     if (!sensor_ok || (cur_w <= cur_b)) begin
                        s_in     = 10'd0;
                        state_in = S_MUL;
                     end else if (raw < cur_b) begin
                        s_in     = invert_ff ? 10'd1000 : 10'd0;
                        state_in = S_MUL;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV1;
                     end
                  end else if (req_data.last_of_scan) begin
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_DIV1: begin
            if (div_stat.done) begin
               s_in     = invert_ff ? 10'd1000 - qc : qc;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (s_ff >= active_thr_ff && active_ff != 5'd31) begin
               active_in = active_ff + 5'd1;
            end
            strength_in = ssum[14] ? 14'd16383 : ssum[13:0];
            prod_in     = weight_of(idx_ff) * signed'({1'b0, sz});
            state_in    = S_ACC;
         end
         S_ACC: begin
            if (wsum > 29'sd134217727) begin
               weighted_in = 28'sd134217727;
            end else if (wsum < -29'sd134217728) begin
               weighted_in = -28'sd134217728;
            end else begin
               weighted_in = 28'(wsum);
            end
            state_in = last_ff ? S_POS : S_IDLE;
         end
         S_POS: begin
            if (strength_ff >= min_sum_ff && strength_ff != 14'd0) begin
               neg_in    = weighted_ff[27];
               div_num   = weighted_ff[27] ? 28'(-weighted_ff) : 28'(weighted_ff);
               div_den   = strength_ff;
               div_start = 1'b1;
               state_in  = S_DIV2;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV2: begin
            if (div_stat.done) begin
               held_in  = neg_ff ? -signed'(pos_mag) : signed'(pos_mag);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the response register is free, then clear the scan
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.line_position  = held_ff;
               rsp_data_in.active_count   = active_ff;
               rsp_data_in.total_strength = strength_ff;
               rsp_data_in.line_found     = locked_ff && (strength_ff >= min_sum_ff);
               rsp_data_in.cal_locked     = locked_ff;
               rsp_valid_in               = 1'b1;
               weighted_in                = '0;
               strength_in                = '0;
               active_in                  = '0;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         min_cal_range_ff <= 12'd200;
         invert_ff        <= 1'b1;
         active_thr_ff    <= 10'd500;
         min_sum_ff       <= 14'd1000;
         for (int i = 0; i < SENSOR_NUM; i++) begin
            white_ff[i] <= '0;
            black_ff[i] <= '0;
         end
         valid_ff     <= '0;
         locked_ff    <= 1'b0;
         weighted_ff  <= '0;
         strength_ff  <= '0;
         active_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         min_cal_range_ff <= min_cal_range_in;
         invert_ff        <= invert_in;
         active_thr_ff    <= active_thr_in;
         min_sum_ff       <= min_sum_in;
         white_ff         <= white_in;
         black_ff         <= black_in;
         valid_ff         <= valid_in;
         locked_ff        <= locked_in;
         weighted_ff      <= weighted_in;
         strength_ff      <= strength_in;
         active_ff        <= active_in;
         held_ff          <= held_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an unlocked response carries no scan totals
   `LSC_ASSERT_IMP(a_unlocked_empty, rsp_valid_ff && !rsp_data_ff.cal_locked, rsp_data_ff.active_count == 5'd0 && rsp_data_ff.total_strength == 14'd0 && !rsp_data_ff.line_found)
   // the lock never drops outside reset
   `LSC_ASSERT_NEXT(a_lock_sticks, locked_ff, locked_ff)
   // the divider runs only while the sequencer waits on it
   `LSC_ASSERT_IMP(a_div_in_wait, div_stat.busy, state_ff == S_DIV1 || state_ff == S_DIV2)
   // the reported position stays inside the end sensor weights
   `LSC_ASSERT_IMP(a_pos_range, rsp_valid_ff, rsp_data_ff.line_position >= -14'sd7500 && rsp_data_ff.line_position <= 14'sd7500)

endmodule
